// ----- src/pkcs7u_pkg.sv -----
// Package with shared constants, codes and control types of the PKCS#7 unpad checker.
package pkcs7u_pkg;

  localparam int BLOCK_BYTES_DEF = 16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LEN      = 2'd1,
    ST_PADVAL   = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  typedef struct packed {
    logic accept;
    logic eval;
    logic load_final;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_last;
    logic end_now;
    logic emit_last;
  } dp_sts_t;

endpackage

// ----- src/pkcs7u_if.sv -----
// Valid/ready channel interfaces for the input byte stream and the result stream.
interface pkcs7u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pkcs7u_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_message;
  logic [1:0] status;

  modport source (output valid, output out_byte, output byte_valid,
                  output end_of_message, output status, input ready);
  modport sink (input valid, input out_byte, input byte_valid,
                input end_of_message, input status, output ready);
endinterface

// ----- src/pkcs7u_datapath.sv -----
// Datapath: delay line, length tracking, padding checks and the output register.
module pkcs7u_datapath #(
  parameter int BLOCK_BYTES = pkcs7u_pkg::BLOCK_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pkcs7u_pkg::ctl_cmd_t  cmd,
  output pkcs7u_pkg::dp_sts_t   sts,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [7:0]            out_byte,
  output logic                  out_byte_valid,
  output logic                  out_end_of_message,
  output logic [1:0]            out_status
);
  import pkcs7u_pkg::*;

  localparam int CW = $clog2(BLOCK_BYTES + 1);
  localparam int LW = $clog2(BLOCK_BYTES);

  logic [7:0]    sr_r [BLOCK_BYTES];
  logic [7:0]    spill_r;
  logic          spill_vld_r;
  logic [CW-1:0] held_r;
  logic [LW-1:0] lm_r;
  logic          len_bad_r;
  logic [CW-1:0] rem_r;
  status_t       stat_r;
  logic          out_vld_r;
  logic [7:0]    out_byte_r;
  logic          out_bv_r;
  logic          out_eom_r;
  status_t       out_stat_r;

  logic          full;
  logic [7:0]    pad;
  logic          mis;
  status_t       stat_nxt;
  logic [CW-1:0] rem_nxt;
  logic          shift_en;
  logic          push_out;

  assign full     = (held_r == CW'(BLOCK_BYTES));
  assign pad      = sr_r[BLOCK_BYTES-1];
  assign push_out = cmd.accept && !in_last_byte && full;
  assign shift_en = cmd.accept || (cmd.emit && !spill_vld_r);

  always_comb begin
    mis = 1'b0;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if ((9'(i) < {1'b0, pad}) && (sr_r[BLOCK_BYTES-1-i] != pad)) begin
        mis = 1'b1;
      end
    end
  end

  always_comb begin
    priority if (len_bad_r) begin
      stat_nxt = ST_LEN;
    end else if ((pad == 8'd0) || (pad > 8'(BLOCK_BYTES))) begin
      stat_nxt = ST_PADVAL;
    end else if (mis) begin
      stat_nxt = ST_MISMATCH;
    end else begin
      stat_nxt = ST_OK;
    end
  end

  assign rem_nxt = CW'(BLOCK_BYTES) - CW'(pad) + CW'(spill_vld_r);

  assign sts.out_free  = !out_vld_r || out_ready;
  assign sts.in_last   = in_last_byte;
  assign sts.end_now   = (stat_nxt != ST_OK) || (rem_nxt == '0);
  assign sts.emit_last = (rem_r == CW'(1));

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int j = 0; j < BLOCK_BYTES - 1; j++) begin
        sr_r[j] <= sr_r[j+1];
      end
      if (cmd.accept) begin
        sr_r[BLOCK_BYTES-1] <= in_data_byte;
      end
    end
    if (cmd.accept && in_last_byte) begin
      spill_r   <= sr_r[0];
      len_bad_r <= (lm_r != LW'(BLOCK_BYTES - 1)) || (held_r < CW'(BLOCK_BYTES - 1));
    end
    if (cmd.eval) begin
      stat_r <= stat_nxt;
      rem_r  <= rem_nxt;
    end else if (cmd.emit) begin
      rem_r <= rem_r - CW'(1);
    end
    if (push_out) begin
      out_byte_r <= sr_r[0];
      out_bv_r   <= 1'b1;
      out_eom_r  <= 1'b0;
      out_stat_r <= ST_OK;
    end else if (cmd.load_final) begin
      out_byte_r <= 8'd0;
      out_bv_r   <= 1'b0;
      out_eom_r  <= 1'b1;
      out_stat_r <= stat_r;
    end else if (cmd.emit) begin
      out_byte_r <= spill_vld_r ? spill_r : sr_r[0];
      out_bv_r   <= 1'b1;
      out_eom_r  <= (rem_r == CW'(1));
      out_stat_r <= ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      lm_r        <= '0;
      spill_vld_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (in_last_byte) begin
          held_r      <= '0;
          lm_r        <= '0;
          spill_vld_r <= full;
        end else begin
          if (!full) begin
            held_r <= held_r + CW'(1);
          end
          lm_r <= (lm_r == LW'(BLOCK_BYTES - 1)) ? '0 : lm_r + LW'(1);
        end
      end else if (cmd.emit) begin
        spill_vld_r <= 1'b0;
      end
      if (push_out || cmd.load_final || cmd.emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_vld_r;
  assign out_byte           = out_byte_r;
  assign out_byte_valid     = out_bv_r;
  assign out_end_of_message = out_eom_r;
  assign out_status         = out_stat_r;

endmodule

// ----- src/pkcs7u_ctrl.sv -----
// Controller: sequences byte intake, the end-of-message check and the closing burst.
module pkcs7u_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output pkcs7u_pkg::ctl_cmd_t cmd,
  input  pkcs7u_pkg::dp_sts_t  sts
);
  import pkcs7u_pkg::*;

  typedef enum logic [1:0] {
    S_RUN,
    S_EVAL,
    S_FINAL,
    S_EMIT
  } state_t;

  state_t state_r;

  assign in_ready       = (state_r == S_RUN) && sts.out_free;
  assign cmd.accept     = in_valid && in_ready;
  assign cmd.eval       = (state_r == S_EVAL);
  assign cmd.load_final = (state_r == S_FINAL) && sts.out_free;
  assign cmd.emit       = (state_r == S_EMIT) && sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
    end else begin
      unique case (state_r)
        S_RUN: begin
          if (cmd.accept && sts.in_last) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_r <= sts.end_now ? S_FINAL : S_EMIT;
        end
        S_FINAL: begin
          if (sts.out_free) begin
            state_r <= S_RUN;
          end
        end
        S_EMIT: begin
          if (sts.out_free && sts.emit_last) begin
            state_r <= S_RUN;
          end
        end
        default: state_r <= S_RUN;
      endcase
    end
  end

endmodule

// ----- src/pkcs7_unpad_checker_top.sv -----
// Top level of the PKCS#7 unpad checker: controller and datapath joined.
//
//   channel    dir   handshake      beat contents
//   in_chan    in    valid/ready    data_byte[7:0], last_byte
//   out_chan   out   valid/ready    out_byte[7:0], byte_valid, end_of_message, status[1:0]
//
// The delay line of BLOCK_BYTES bytes releases its oldest byte once it is full.
// A last byte leads to a check state, then a burst of up to BLOCK_BYTES result
// beats, one beat per cycle unless the output stalls, set by the single output
// register. Reset clears counts, control and the output valid. A stall on the
// output holds the input until the output register frees.
module pkcs7_unpad_checker_top #(
  parameter int BLOCK_BYTES = pkcs7u_pkg::BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pkcs7u_in_if.sink   in_chan,
  pkcs7u_out_if.source out_chan
);
  import pkcs7u_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  pkcs7u_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pkcs7u_datapath #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_data_byte       (in_chan.data_byte),
    .in_last_byte       (in_chan.last_byte),
    .out_ready          (out_chan.ready),
    .out_valid          (out_chan.valid),
    .out_byte           (out_chan.out_byte),
    .out_byte_valid     (out_chan.byte_valid),
    .out_end_of_message (out_chan.end_of_message),
    .out_status         (out_chan.status)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench: directed and random PKCS#7 messages in, unpadded bytes and status checked out.
typedef struct {
  logic [7:0]          out_byte;
  logic                byte_valid;
  logic                end_of_message;
  pkcs7u_pkg::status_t status;
} unpad_beat_t;

class unpad_scoreboard;
  localparam int BLK = pkcs7u_pkg::BLOCK_BYTES_DEF;

  logic [7:0]  line_bytes[BLK];
  int unsigned line_fill;
  int unsigned len_mod;
  unpad_beat_t expected_beats[$];
  int unsigned errors;

  function new();
    line_fill = 0;
    len_mod   = 0;
    errors    = 0;
  endfunction

  function void push_beat(logic [7:0] b, logic v, logic e, pkcs7u_pkg::status_t st);
    unpad_beat_t r;
    r.out_byte       = b;
    r.byte_valid     = v;
    r.end_of_message = e;
    r.status         = st;
    expected_beats.push_back(r);
  endfunction

  function void note_input(logic [7:0] b, logic is_last);
    logic [7:0]          win[BLK+1];
    int unsigned         n, pad, plain, lm;
    pkcs7u_pkg::status_t st;
    if (!is_last) begin
      len_mod = (len_mod + 1) % BLK;
      if (line_fill == BLK) begin
        push_beat(line_bytes[0], 1'b1, 1'b0, pkcs7u_pkg::ST_OK);
        for (int i = 0; i < BLK - 1; i++) line_bytes[i] = line_bytes[i+1];
        line_bytes[BLK-1] = b;
      end else begin
        line_bytes[line_fill] = b;
        line_fill++;
      end
      return;
    end
    for (int i = 0; i < line_fill; i++) win[i] = line_bytes[i];
    win[line_fill] = b;
    n = line_fill + 1;
    lm = (len_mod + 1) % BLK;
    line_fill = 0;
    len_mod = 0;
    st = pkcs7u_pkg::ST_OK;
    pad = 0;
    if (lm != 0 || n < BLK) begin
      st = pkcs7u_pkg::ST_LEN;
    end else begin
      pad = 32'(win[n-1]);
      if (pad == 0 || pad > BLK) begin
        st = pkcs7u_pkg::ST_PADVAL;
      end else begin
        for (int i = 0; i < pad; i++) begin
          if (win[n-1-i] != pad) begin
            st = pkcs7u_pkg::ST_MISMATCH;
            break;
          end
        end
      end
    end
    if (st != pkcs7u_pkg::ST_OK) begin
      push_beat(8'h00, 1'b0, 1'b1, st);
      return;
    end
    plain = n - pad;
    if (plain == 0) begin
      push_beat(8'h00, 1'b0, 1'b1, pkcs7u_pkg::ST_OK);
      return;
    end
    for (int k = 0; k < plain; k++)
      push_beat(win[k], 1'b1, (k + 1 == plain), pkcs7u_pkg::ST_OK);
  endfunction

  function void check_result(unpad_beat_t act);
    unpad_beat_t exp_beat;
    if (expected_beats.size() == 0) begin
      $error("unexpected result beat: out_byte %0h byte_valid %0b end_of_message %0b status %0d",
             act.out_byte, act.byte_valid, act.end_of_message, act.status);
      errors++;
      return;
    end
    exp_beat = expected_beats.pop_front();
    if (act.out_byte !== exp_beat.out_byte) begin
      $error("out_byte: expected %0h, got %0h", exp_beat.out_byte, act.out_byte);
      errors++;
    end
    if (act.byte_valid !== exp_beat.byte_valid) begin
      $error("byte_valid: expected %0b, got %0b", exp_beat.byte_valid, act.byte_valid);
      errors++;
    end
    if (act.end_of_message !== exp_beat.end_of_message) begin
      $error("end_of_message: expected %0b, got %0b", exp_beat.end_of_message,
             act.end_of_message);
      errors++;
    end
    if (act.status !== exp_beat.status) begin
      $error("status: expected %0d, got %0d", exp_beat.status, act.status);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_beats.size();
  endfunction
endclass

module testbench;
  import pkcs7u_pkg::*;

  localparam int BLK            = BLOCK_BYTES_DEF;
  localparam int RANDOM_BYTES   = 230;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;

  logic clk;
  logic rst_n;

  pkcs7u_in_if  in_chan();
  pkcs7u_out_if out_chan();

  pkcs7_unpad_checker_top #(.BLOCK_BYTES(BLK)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  unpad_scoreboard sb = new();
  int unsigned bytes_sent;
  bit          tx_no_gaps;
  bit          rx_no_stalls;
  int unsigned idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    gap = tx_no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.last_byte <= is_last;
    do @(posedge clk); while (!(in_chan.valid && in_chan.ready));
    sb.note_input(b, is_last);
    bytes_sent++;
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
  endtask

  task automatic send_random_message();
    logic [7:0]  msg[$];
    int unsigned kind, len, pad, j, r;
    kind = $urandom_range(0, 99);
    r = $urandom_range(0, 9);
    len = (r < 7) ? BLK : (r < 9) ? 2 * BLK : 3 * BLK;
    if (kind >= 84) begin
      len = $urandom_range(1, 3 * BLK - 1);
      if (len % BLK == 0) len++;
    end
    for (int i = 0; i < len; i++) msg.push_back(8'($urandom_range(0, 255)));
    if (kind < 60) begin
      pad = $urandom_range(1, BLK);
      for (int i = 0; i < pad; i++) msg[len-1-i] = 8'(pad);
    end else if (kind < 72) begin
      msg[len-1] = ($urandom_range(0, 1) == 1) ? 8'h00 : 8'($urandom_range(BLK + 1, 255));
    end else if (kind < 84) begin
      pad = $urandom_range(2, BLK);
      for (int i = 0; i < pad; i++) msg[len-1-i] = 8'(pad);
      j = $urandom_range(1, pad - 1);
      msg[len-1-j] = 8'(pad) ^ 8'($urandom_range(1, 255));
    end else if ($urandom_range(0, 1) == 1) begin
      msg[len-1] = 8'($urandom_range(1, BLK));
    end
    tx_no_gaps = ($urandom_range(0, 3) == 0);
    send_message(msg);
  endtask

  initial begin
    logic [7:0] msg[$];
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.data_byte <= 8'h00;
    in_chan.last_byte <= 1'b0;
    bytes_sent = 0;
    tx_no_gaps = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    msg = '{8'hFF};
    send_message(msg);
    msg = '{8'h00, 8'h80, 8'h01};
    send_message(msg);
    msg = {};
    for (int i = 0; i < BLK; i++) msg.push_back(8'(BLK));
    send_message(msg);

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) send_random_message();

    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    unpad_beat_t act;
    int unsigned hold;
    out_chan.ready <= 1'b0;
    rx_no_stalls = 1'b0;
    hold = 0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_chan.valid && out_chan.ready) begin
        act.out_byte       = out_chan.out_byte;
        act.byte_valid     = out_chan.byte_valid;
        act.end_of_message = out_chan.end_of_message;
        act.status         = status_t'(out_chan.status);
        sb.check_result(act);
      end
      if ($urandom_range(0, 199) == 0) rx_no_stalls = ~rx_no_stalls;
      if (hold > 0) begin
        out_chan.ready <= 1'b0;
        hold--;
      end else begin
        out_chan.ready <= 1'b1;
        if (!rx_no_stalls && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
